[sv/csc_pkg.sv]
// Shared types and constants for the pull-style gather block.
// Used by csc_front, csc_queue, csc_back and csc_pull_gather_sum; no dependencies.
package csc_pkg;

    localparam int KIND_W   = 2;
    localparam int VTX_W    = 10;
    localparam int PROP_W   = 32;
    localparam int SLOT_W   = 12;
    localparam int RANGE_W  = 13;
    localparam int TOTAL_W  = 44;

    localparam logic [KIND_W-1:0] KIND_PROP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    // Commands handed from the front to the back
    typedef enum logic [1:0] {
        OP_WPROP,
        OP_WNBR,
        OP_SWEEP,
        OP_EMPTY
    } op_t;

    // vtx: property index, source vertex or destination vertex
    // first: edge slot for neighbour writes, range start for sweeps
    typedef struct packed {
        op_t                      op;
        logic [VTX_W-1:0]         vtx;
        logic [PROP_W-1:0]        value;
        logic [RANGE_W-1:0]       first;
        logic [RANGE_W-1:0]       last;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

endpackage

[sv/csc_pull_gather_sum.sv]
// Top level of the pull-style gather block: front end, command queue, back end.
// Depends on csc_pkg, csc_front, csc_queue and csc_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_stall  | kind, prop_index, prop_value, edge_slot,
//           |                      | source_vertex, dest_vertex, range_begin, range_end
//  output   | out_valid / out_stall| vertex, total
//
// An idle back end pops and applies a property or neighbour write in the cycle it
// reaches the queue head. A sweep over n neighbour entries is walked with one
// neighbour-memory read per cycle, then the read/accumulate pipeline drains.
// An empty range goes straight to the drain state.
// Reset clears the control state only; both memories hold garbage until written.
// in_stall rises only when the queue is full; a held result holds the back end before its next sum.
module csc_pull_gather_sum
    import csc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [KIND_W-1:0]          kind,
    input  logic [VTX_W-1:0]           prop_index,
    input  logic signed [PROP_W-1:0]   prop_value,
    input  logic [SLOT_W-1:0]          edge_slot,
    input  logic [VTX_W-1:0]           source_vertex,
    input  logic [VTX_W-1:0]           dest_vertex,
    input  logic [RANGE_W-1:0]         range_begin,
    input  logic [RANGE_W-1:0]         range_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [VTX_W-1:0]           vertex,
    output logic signed [TOTAL_W-1:0]  total
);

    logic push, pop, queue_full, queue_not_empty;
    cmd_t push_cmd, head_cmd;

    csc_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .prop_index    (prop_index),
        .prop_value    (prop_value),
        .edge_slot     (edge_slot),
        .source_vertex (source_vertex),
        .dest_vertex   (dest_vertex),
        .range_begin   (range_begin),
        .range_end     (range_end),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    csc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (queue_not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .vertex    (vertex),
        .total     (total)
    );

endmodule

[sv/csc_front.sv]
// Front end: accepts input transactions, drops the ones with no effect and
// turns the rest into commands for the queue. Depends on csc_pkg.
module csc_front
    import csc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
)
(
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [VTX_W-1:0]    prop_index,
    input  logic signed [PROP_W-1:0] prop_value,
    input  logic [SLOT_W-1:0]   edge_slot,
    input  logic [VTX_W-1:0]    source_vertex,
    input  logic [VTX_W-1:0]    dest_vertex,
    input  logic [RANGE_W-1:0]  range_begin,
    input  logic [RANGE_W-1:0]  range_end,
    input  logic                queue_full,
    output logic                push,
    output cmd_t                cmd
);

    logic               accept;
    logic [RANGE_W-1:0] last_c;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // clamp the range end to the neighbour store size
    assign last_c = (32'(range_end) > 32'(MAX_EDGES)) ? RANGE_W'(MAX_EDGES) : range_end;

    always_comb
    begin
        cmd  = '0;
        push = 1'b0;
        case (kind)
            KIND_PROP:
            begin
                cmd.op    = OP_WPROP;
                cmd.vtx   = prop_index;
                cmd.value = prop_value;
                push      = accept && (32'(prop_index) < 32'(MAX_VERTICES));
            end
            KIND_EDGE:
            begin
                cmd.op    = OP_WNBR;
                cmd.vtx   = source_vertex;
                cmd.first = RANGE_W'(edge_slot);
                push      = accept && (32'(edge_slot) < 32'(MAX_EDGES));
            end
            KIND_SWEEP:
            begin
                cmd.op    = (range_begin < last_c) ? OP_SWEEP : OP_EMPTY;
                cmd.vtx   = dest_vertex;
                cmd.first = range_begin;
                cmd.last  = last_c;
                push      = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

[sv/csc_queue.sv]
// Short command queue between the front and the back.
// Depends on csc_pkg for the command type.
module csc_queue
    import csc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic not_empty,
    output logic full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          slots [DEPTH];
    logic [PW:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW:0]   rd_ptr_reg, rd_ptr_next;

    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]) &&
                       (wr_ptr_reg[PW] != rd_ptr_reg[PW]);
    assign head      = slots[rd_ptr_reg[PW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (PW+1)'(push && !full);
    assign rd_ptr_next = rd_ptr_reg + (PW+1)'(pop && not_empty);

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slots[wr_ptr_reg[PW-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

[sv/csc_back.sv]
// Back end: owns the property and neighbour memories, applies writes and
// walks neighbour ranges through a three-step read/accumulate pipeline.
// Depends on csc_pkg.
module csc_back
    import csc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  logic                       cmd_valid,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [VTX_W-1:0]           vertex,
    output logic signed [TOTAL_W-1:0]  total
);

    localparam int VA_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VX_W    = (VA_W > VTX_W) ? VA_W : VTX_W;
    localparam int EX_W    = (EA_W > RANGE_W) ? EA_W : RANGE_W;
    localparam int ACC_RAW = 33 + $clog2(MAX_EDGES + 1);
    localparam int ACC_W   = (ACC_RAW > TOTAL_W) ? ACC_RAW : TOTAL_W;

    logic [PROP_W-1:0] prop_mem [MAX_VERTICES];
    logic [VTX_W-1:0]  nb_mem   [MAX_EDGES];

    state_t                     state_reg, state_next;
    logic [RANGE_W-1:0]         ptr_reg, ptr_next;
    logic [RANGE_W-1:0]         last_reg, last_next;
    logic [VTX_W-1:0]           vtx_reg, vtx_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s2_valid_reg, s2_valid_next;
    logic                       s2_keep_reg, s2_keep_next;
    logic [VTX_W-1:0]           nb_rdata_reg;
    logic signed [PROP_W-1:0]   prop_rdata_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [VTX_W-1:0]           out_vertex_reg, out_vertex_next;
    logic signed [TOTAL_W-1:0]  out_total_reg, out_total_next;

    logic                       prop_we, nb_we, nb_re;
    logic [VX_W-1:0]            wvtx_ext, src_ext;
    logic [EX_W-1:0]            wslot_ext, ptr_ext;
    logic [VA_W-1:0]            prop_waddr, prop_raddr;
    logic [EA_W-1:0]            nb_waddr, nb_raddr;
    logic                       src_keep;
    logic                       out_free;
    logic signed [TOTAL_W-1:0]  sat_total;

    assign wvtx_ext   = VX_W'(cmd.vtx);
    assign prop_waddr = wvtx_ext[VA_W-1:0];
    assign wslot_ext  = EX_W'(cmd.first);
    assign nb_waddr   = wslot_ext[EA_W-1:0];
    assign ptr_ext    = EX_W'(ptr_reg);
    assign nb_raddr   = ptr_ext[EA_W-1:0];
    assign src_ext    = VX_W'(nb_rdata_reg);
    assign prop_raddr = src_ext[VA_W-1:0];
    assign src_keep   = 32'(nb_rdata_reg) < 32'(MAX_VERTICES);

    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (acc_reg > ACC_W'(TOTAL_MAX))
        begin
            sat_total = TOTAL_MAX;
        end
        else if (acc_reg < ACC_W'(TOTAL_MIN))
        begin
            sat_total = TOTAL_MIN;
        end
        else
        begin
            sat_total = acc_reg[TOTAL_W-1:0];
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (prop_we)
        begin
            prop_mem[prop_waddr] <= cmd.value;
        end
        if (s1_valid_reg)
        begin
            prop_rdata_reg <= prop_mem[prop_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= cmd.vtx;
        end
        if (nb_re)
        begin
            nb_rdata_reg <= nb_mem[nb_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        last_next       = last_reg;
        vtx_next        = vtx_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_vertex_next = out_vertex_reg;
        out_total_next  = out_total_reg;
        pop             = 1'b0;
        prop_we         = 1'b0;
        nb_we           = 1'b0;
        nb_re           = 1'b0;

        s1_valid_next   = 1'b0;
        s2_valid_next   = s1_valid_reg;
        s2_keep_next    = s1_valid_reg && src_keep;

        if (s2_valid_reg && s2_keep_reg)
        begin
            acc_next = acc_reg + ACC_W'(prop_rdata_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_WPROP:
                        begin
                            prop_we = 1'b1;
                        end
                        OP_WNBR:
                        begin
                            nb_we = 1'b1;
                        end
                        OP_SWEEP:
                        begin
                            ptr_next   = cmd.first;
                            last_next  = cmd.last;
                            vtx_next   = cmd.vtx;
                            acc_next   = '0;
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            vtx_next   = cmd.vtx;
                            acc_next   = '0;
                            state_next = ST_DRAIN;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // issue one neighbour read per cycle
                nb_re         = 1'b1;
                s1_valid_next = 1'b1;
                ptr_next      = ptr_reg + RANGE_W'(1);
                if (ptr_next == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = vtx_reg;
                    out_total_next  = sat_total;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_keep_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s2_keep_reg   <= s2_keep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        last_reg       <= last_next;
        vtx_reg        <= vtx_next;
        acc_reg        <= acc_next;
        out_vertex_reg <= out_vertex_next;
        out_total_reg  <= out_total_next;
    end

    assign out_valid = out_valid_reg;
    assign vertex    = out_vertex_reg;
    assign total     = out_total_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for csc_pull_gather_sum: loads properties and neighbour
// lists, sweeps destination ranges, and compares each sum with a local gather model.
// Depends on csc_pkg and csc_pull_gather_sum.
`timescale 1ns / 1ps

module tb_top
    import csc_pkg::*;
();

    localparam int VERTEX_COUNT   = 1024;
    localparam int SLOT_COUNT     = 4096;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VTX_W-1:0]   prop_index;
        logic [PROP_W-1:0]  prop_value;
        logic [SLOT_W-1:0]  edge_slot;
        logic [VTX_W-1:0]   source_vertex;
        logic [VTX_W-1:0]   dest_vertex;
        logic [RANGE_W-1:0] range_begin;
        logic [RANGE_W-1:0] range_end;
    } gather_cmd_t;

    typedef struct {
        logic [VTX_W-1:0]          vertex;
        logic signed [TOTAL_W-1:0] total;
    } vertex_sum_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [KIND_W-1:0]         kind = '0;
    logic [VTX_W-1:0]          prop_index = '0;
    logic signed [PROP_W-1:0]  prop_value = '0;
    logic [SLOT_W-1:0]         edge_slot = '0;
    logic [VTX_W-1:0]          source_vertex = '0;
    logic [VTX_W-1:0]          dest_vertex = '0;
    logic [RANGE_W-1:0]        range_begin = '0;
    logic [RANGE_W-1:0]        range_end = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [VTX_W-1:0]          vertex;
    logic signed [TOTAL_W-1:0] total;

    // Local copy of both stores, plus which entries hold defined data
    logic signed [PROP_W-1:0] prop_mem [VERTEX_COUNT];
    logic [VTX_W-1:0]         nbr_mem [SLOT_COUNT];
    bit                       prop_written [VERTEX_COUNT];
    bit                       nbr_written [SLOT_COUNT];
    int                       known_vertices [$];

    vertex_sum_t pending_sums [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int sums_checked = 0;
    int n_writes = 0;
    int n_sweeps = 0;
    int n_empty = 0;
    int n_ignored = 0;

    csc_pull_gather_sum u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .prop_index    (prop_index),
        .prop_value    (prop_value),
        .edge_slot     (edge_slot),
        .source_vertex (source_vertex),
        .dest_vertex   (dest_vertex),
        .range_begin   (range_begin),
        .range_end     (range_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex        (vertex),
        .total         (total)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Exact gather over [lo, hi) with the end clamped to the store size
    function automatic logic signed [TOTAL_W-1:0] gather_sum(input int lo, input int hi);
        longint acc;
        int     stop;
        acc = 0;
        stop = (hi > SLOT_COUNT) ? SLOT_COUNT : hi;
        for (int j = lo; j < stop; j++)
        begin
            if (nbr_mem[j] < VERTEX_COUNT)
                acc += longint'(prop_mem[nbr_mem[j]]);
        end
        if (acc > longint'(TOTAL_MAX))
            acc = longint'(TOTAL_MAX);
        if (acc < longint'(TOTAL_MIN))
            acc = longint'(TOTAL_MIN);
        return acc[TOTAL_W-1:0];
    endfunction

    function automatic bit slot_defined(input int j);
        return nbr_written[j] && prop_written[nbr_mem[j]];
    endfunction

    // First slot at or after lo whose read would touch undefined data
    function automatic int usable_end(input int lo);
        int j;
        j = lo;
        while (j < SLOT_COUNT && slot_defined(j))
            j++;
        return j;
    endfunction

    function automatic gather_cmd_t random_cmd(input logic [KIND_W-1:0] k);
        gather_cmd_t c;
        c.kind          = k;
        c.prop_index    = VTX_W'($urandom);
        c.prop_value    = $urandom;
        c.edge_slot     = SLOT_W'($urandom);
        c.source_vertex = VTX_W'($urandom);
        c.dest_vertex   = VTX_W'($urandom);
        c.range_begin   = RANGE_W'($urandom);
        c.range_end     = RANGE_W'($urandom);
        return c;
    endfunction

    function automatic gather_cmd_t prop_cmd(input int idx, input logic [PROP_W-1:0] val);
        gather_cmd_t c;
        c = random_cmd(KIND_PROP);
        c.prop_index = VTX_W'(idx);
        c.prop_value = val;
        return c;
    endfunction

    function automatic gather_cmd_t edge_cmd(input int slot, input int src);
        gather_cmd_t c;
        c = random_cmd(KIND_EDGE);
        c.edge_slot     = SLOT_W'(slot);
        c.source_vertex = VTX_W'(src);
        return c;
    endfunction

    // Cut the range short where it would reach an entry never written
    function automatic gather_cmd_t sweep_cmd(input int dest, input int lo, input int hi);
        gather_cmd_t c;
        int          stop;
        int          lim;
        stop = (hi > SLOT_COUNT) ? SLOT_COUNT : hi;
        if (stop > lo)
        begin
            lim = usable_end(lo);
            if (lim < stop)
                hi = lim;
        end
        c = random_cmd(KIND_SWEEP);
        c.dest_vertex = VTX_W'(dest);
        c.range_begin = RANGE_W'(lo);
        c.range_end   = RANGE_W'(hi);
        return c;
    endfunction

    function automatic logic [PROP_W-1:0] pick_property();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_source();
        if (known_vertices.size() == 0 || $urandom_range(19) == 0)
            return $urandom_range(VERTEX_COUNT - 1);
        return known_vertices[$urandom_range(known_vertices.size() - 1)];
    endfunction

    // Update the local stores and queue the expected sum for an accepted transaction
    task automatic apply_cmd(input gather_cmd_t c);
        vertex_sum_t s;
        int          stop;
        case (c.kind)
            KIND_PROP:
            begin
                if (!prop_written[c.prop_index])
                    known_vertices.push_back(int'(c.prop_index));
                prop_mem[c.prop_index]     = c.prop_value;
                prop_written[c.prop_index] = 1'b1;
                n_writes++;
            end
            KIND_EDGE:
            begin
                nbr_mem[c.edge_slot]     = c.source_vertex;
                nbr_written[c.edge_slot] = 1'b1;
                n_writes++;
            end
            KIND_SWEEP:
            begin
                stop = (int'(c.range_end) > SLOT_COUNT) ? SLOT_COUNT : int'(c.range_end);
                if (stop <= int'(c.range_begin))
                    n_empty++;
                s.vertex = c.dest_vertex;
                s.total  = gather_sum(int'(c.range_begin), int'(c.range_end));
                pending_sums.push_back(s);
                n_sweeps++;
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic send_cmd(input gather_cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        kind          <= c.kind;
        prop_index    <= c.prop_index;
        prop_value    <= c.prop_value;
        edge_slot     <= c.edge_slot;
        source_vertex <= c.source_vertex;
        dest_vertex   <= c.dest_vertex;
        range_begin   <= c.range_begin;
        range_end     <= c.range_end;
        // hold the payload until the transaction is taken
        do
            @(posedge clk);
        while (in_stall);
        apply_cmd(c);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        vertex_sum_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected sum transaction: vertex %0d, total %0d", vertex, total);
                errors++;
            end
            else
            begin
                want = pending_sums.pop_front();
                sums_checked++;
                if (vertex !== want.vertex)
                begin
                    $error("vertex mismatch: expected %0d, actual %0d", want.vertex, vertex);
                    errors++;
                end
                if (total !== want.total)
                begin
                    $error("total mismatch: expected %0d, actual %0d", want.total, total);
                    errors++;
                end
            end
        end
    end

    // Properties at both ends of the range, slots at both ends of the store
    task automatic test_store_extremes();
        send_cmd(prop_cmd(0, 32'h7FFF_FFFF));
        send_cmd(prop_cmd(VERTEX_COUNT - 1, 32'h8000_0000));
        send_cmd(prop_cmd(512, 32'hFFFF_FFFF));
        send_cmd(prop_cmd(341, 32'h0001_0000));
        send_cmd(edge_cmd(0, 0));
        send_cmd(edge_cmd(1, VERTEX_COUNT - 1));
        send_cmd(edge_cmd(2, 512));
        send_cmd(edge_cmd(SLOT_COUNT - 1, VERTEX_COUNT - 1));
        send_cmd(edge_cmd(SLOT_COUNT - 2, 0));
        send_cmd(edge_cmd(2048, 341));
        send_cmd(sweep_cmd(0, 0, 3));
        send_cmd(sweep_cmd(682, 2048, 2049));
        send_cmd(sweep_cmd(VERTEX_COUNT - 1, SLOT_COUNT - 1, SLOT_COUNT));
    endtask

    // Empty ranges, reversed ranges and an end past the store
    task automatic test_empty_and_clamped_ranges();
        send_cmd(sweep_cmd(VERTEX_COUNT - 1, 0, 0));
        send_cmd(sweep_cmd(5, 3, 1));
        send_cmd(sweep_cmd(9, SLOT_COUNT, SLOT_COUNT));
        send_cmd(sweep_cmd(0, 8191, 0));
        send_cmd(sweep_cmd(7, SLOT_COUNT - 2, 8191));
        send_cmd(prop_cmd(VERTEX_COUNT - 1, 32'h7FFF_FFFF));
        send_cmd(sweep_cmd(7, SLOT_COUNT - 2, 8191));
    endtask

    // Kind 3 must leave both stores alone and give no result
    task automatic test_ignored_kind();
        gather_cmd_t c;
        c = random_cmd(KIND_UNUSED);
        c.prop_index    = '1;
        c.prop_value    = '1;
        c.edge_slot     = '1;
        c.source_vertex = '1;
        c.dest_vertex   = '1;
        c.range_begin   = '1;
        c.range_end     = '1;
        send_cmd(c);
        send_cmd(random_cmd(KIND_UNUSED));
        send_cmd(sweep_cmd(1, 0, 3));
    endtask

    // Long lists of extreme properties drive the upper bits of the sum
    task automatic test_wide_sums();
        send_cmd(prop_cmd(VERTEX_COUNT - 1, 32'h8000_0000));
        for (int j = 256; j < 512; j++)
            send_cmd(edge_cmd(j, VERTEX_COUNT - 1));
        send_cmd(sweep_cmd(100, 256, 512));
        send_cmd(prop_cmd(VERTEX_COUNT - 1, 32'h7FFF_FFFF));
        send_cmd(sweep_cmd(101, 256, 512));
    endtask

    // Build neighbour lists in blocks and sweep mostly over what was just built
    task automatic test_random_graph(input int n_items, input int idle, input int stall);
        int sent;
        int pick;
        int shape;
        int len;
        int base;
        int blk_base;
        int blk_len;
        int lo;
        int hi;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        blk_base  = 0;
        blk_len   = 1;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                send_cmd(prop_cmd($urandom_range(VERTEX_COUNT - 1), pick_property()));
                sent++;
            end
            else if (pick < 20)
            begin
                send_cmd(random_cmd(KIND_UNUSED));
            end
            else if (pick < 45)
            begin
                len  = $urandom_range(16, 1);
                base = $urandom_range(SLOT_COUNT - len);
                for (int j = 0; j < len; j++)
                    send_cmd(edge_cmd(base + j, pick_source()));
                sent += len;
                blk_base = base;
                blk_len  = len;
            end
            else
            begin
                shape = $urandom_range(99);
                if (shape < 15)
                begin
                    lo = blk_base;
                    hi = blk_base + blk_len;
                end
                else if (shape < 60)
                begin
                    lo = blk_base + $urandom_range(blk_len - 1);
                    hi = lo + $urandom_range(blk_len + 2);
                end
                else if (shape < 85)
                begin
                    lo = $urandom_range(SLOT_COUNT);
                    hi = lo + $urandom_range(32);
                end
                else if (shape < 90)
                begin
                    lo = $urandom_range(SLOT_COUNT - 1);
                    hi = lo + $urandom_range(300, 32);
                end
                else
                begin
                    lo = $urandom_range(8191);
                    hi = $urandom_range(8191);
                end
                send_cmd(sweep_cmd($urandom_range(VERTEX_COUNT - 1), lo, hi));
                sent++;
            end
        end
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("csc_pull_gather_sum test failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_store_extremes();
        test_empty_and_clamped_ranges();
        test_ignored_kind();
        test_wide_sums();
        test_random_graph(300, 0, 0);
        // let the block run dry before loading more
        hold_until_drained();
        test_random_graph(300, 67, 0);
        test_random_graph(300, 0, 67);
        test_random_graph(300, 17, 17);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d store writes, %0d ignored items and %0d sweeps (%0d empty)",
                 n_writes, n_ignored, n_sweeps, n_empty);
        $display("checked %0d vertex sums over %0d loaded vertices",
                 sums_checked, known_vertices.size());
        if (errors == 0 && pending_sums.size() == 0)
            $display("csc_pull_gather_sum test passed");
        else
            $display("csc_pull_gather_sum test failed");
        $finish;
    end

endmodule

[csc_pull_gather_sum.f]
sv/csc_pkg.sv
sv/csc_front.sv
sv/csc_queue.sv
sv/csc_back.sv
sv/csc_pull_gather_sum.sv
tb/tb_top.sv
